FILE: hdl/sal_pkg.sv
`default_nettype none

package sal_pkg;

   localparam int DATA_W    = 32;
   localparam int CNT_W     = 7;
   localparam int FUNC_W    = 3;
   localparam int STATUS_W  = 2;
   localparam int DEPTH_DEF = 64;

   typedef enum logic [FUNC_W-1:0] {
      FN_READ   = 3'd0,
      FN_INSERT = 3'd1,
      FN_REMOVE = 3'd2,
      FN_FWD    = 3'd3,
      FN_BWD    = 3'd4
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_EMIT,
      ST_REPORT
   } state_type;

   // One result handed from the sequencer to the output register.
   typedef struct packed {
      logic                     load;
      logic signed [DATA_W-1:0] value;
      status_type               status;
      logic [CNT_W-1:0]         count;
      logic                     last;
   } res_type;

endpackage

`default_nettype wire

FILE: hdl/shifting_array_list.sv
// Densely packed ordered list of up to DEPTH signed 32-bit words held in one
// synchronous RAM. One request is handled at a time; a request is taken while
// the previous result may still sit in the output register. A traversal
// streams one word per cycle as fast as the result side takes them. Insert and
// remove move each later word through the RAM read and write ports at one word
// per cycle. Flagged requests (full, out of range, empty) and unused selectors
// give one result and leave the list unchanged. The next request can be taken
// in the cycle after the last result of the previous one is loaded. The RAM
// needs no clearing after reset: only positions below the fill level are ever
// read.
`default_nettype none

module shifting_array_list #(
   parameter int DEPTH = sal_pkg::DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [sal_pkg::FUNC_W-1:0]        req_func,
   input  wire logic [sal_pkg::CNT_W-1:0]         req_pos,
   input  wire logic signed [sal_pkg::DATA_W-1:0] req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [sal_pkg::DATA_W-1:0]      rsp_value,
   output logic [sal_pkg::STATUS_W-1:0]           rsp_status,
   output logic [sal_pkg::CNT_W-1:0]              rsp_count,
   output logic                                   rsp_last
);

   import sal_pkg::*;

   localparam int AW = $clog2(DEPTH);

   res_type                  res;
   logic                     out_free;
   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic [DATA_W-1:0]        mem_wdata;
   logic                     mem_re;
   logic [AW-1:0]            mem_raddr;
   logic [DATA_W-1:0]        mem_rdata;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] value_ff;
   status_type               status_ff;
   logic [CNT_W-1:0]         count_ff;
   logic                     last_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   sal_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   sal_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_pos   (req_pos),
      .req_data  (req_data),
      .out_free  (out_free),
      .res       (res),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   // Output register: holds a result until the result side takes it.
   assign rsp_valid_in = res.load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res.load) begin
         value_ff  <= res.value;
         status_ff <= res.status;
         count_ff  <= res.count;
         last_ff   <= res.last;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = value_ff;
   assign rsp_status = status_ff;
   assign rsp_count  = count_ff;
   assign rsp_last   = last_ff;

endmodule

`default_nettype wire

FILE: hdl/sal_ram.sv
`default_nettype none

module sal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: hdl/sal_ctrl.sv
`default_nettype none

module sal_ctrl #(
   parameter int DEPTH = sal_pkg::DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [sal_pkg::FUNC_W-1:0]        req_func,
   input  wire logic [sal_pkg::CNT_W-1:0]         req_pos,
   input  wire logic signed [sal_pkg::DATA_W-1:0] req_data,
   input  wire logic                              out_free,
   output sal_pkg::res_type                       res,
   output logic                                   mem_we,
   output logic [$clog2(DEPTH)-1:0]               mem_waddr,
   output logic [sal_pkg::DATA_W-1:0]             mem_wdata,
   output logic                                   mem_re,
   output logic [$clog2(DEPTH)-1:0]               mem_raddr,
   input  wire logic [sal_pkg::DATA_W-1:0]        mem_rdata
);

   import sal_pkg::*;

   localparam int AW = $clog2(DEPTH);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic [AW-1:0]      rd_addr_ff, rd_addr_in;
   logic [AW-1:0]      wr_addr_ff, wr_addr_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic [DATA_W-1:0]  data_ff, data_in;
   status_type         status_ff, status_in;
   logic               wr_pend_ff, wr_pend_in;
   logic               have_ff, have_in;
   logic               ins_ff, ins_in;
   logic               fwd_ff, fwd_in;

   state_type          dec_state;
   status_type         dec_status;
   logic [AW-1:0]      dec_rd;
   logic [CNT_W-1:0]   dec_left;
   logic               dec_ins;
   logic               dec_fwd;
   logic [CNT_W-1:0]   cnt_m1;
   logic [CNT_W-1:0]   pos_p1;
   logic [AW-1:0]      rd_step;

   assign cnt_m1  = count_ff - CNT_W'(1);
   assign pos_p1  = req_pos + CNT_W'(1);
   assign rd_step = fwd_ff ? rd_addr_ff + AW'(1) : rd_addr_ff - AW'(1);

   // Decode of a new request against the current fill level.
   always_comb begin
      dec_state  = ST_REPORT;
      dec_status = STAT_OK;
      dec_rd     = '0;
      dec_left   = '0;
      dec_ins    = 1'b0;
      dec_fwd    = 1'b1;
      unique case (func_type'(req_func))
         FN_READ: begin
            if (count_ff == '0) begin
               dec_status = STAT_EMPTY;
            end else if (req_pos >= count_ff) begin
               dec_status = STAT_RANGE;
            end else begin
               dec_state = ST_EMIT;
               dec_rd    = req_pos[AW-1:0];
               dec_left  = CNT_W'(1);
            end
         end
         FN_INSERT: begin
            if (count_ff >= CNT_W'(DEPTH)) begin
               dec_status = STAT_FULL;
            end else if (req_pos > count_ff) begin
               dec_status = STAT_RANGE;
            end else begin
               // Words move up from the top end down to the insertion point.
               dec_state = ST_SHIFT;
               dec_ins   = 1'b1;
               dec_fwd   = 1'b0;
               dec_rd    = cnt_m1[AW-1:0];
               dec_left  = count_ff - req_pos;
            end
         end
         FN_REMOVE: begin
            if (count_ff == '0) begin
               dec_status = STAT_EMPTY;
            end else if (req_pos >= count_ff) begin
               dec_status = STAT_RANGE;
            end else begin
               dec_state = ST_SHIFT;
               dec_rd    = pos_p1[AW-1:0];
               dec_left  = cnt_m1 - req_pos;
            end
         end
         FN_FWD, FN_BWD: begin
            if (count_ff == '0) begin
               dec_status = STAT_EMPTY;
            end else begin
               dec_state = ST_EMIT;
               dec_left  = count_ff;
               dec_fwd   = (func_type'(req_func) == FN_FWD);
               dec_rd    = dec_fwd ? '0 : cnt_m1[AW-1:0];
            end
         end
         default: begin
            dec_status = STAT_OK;
         end
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = dec_state;
            end
         end
         ST_SHIFT: begin
            if (left_ff == '0 && !wr_pend_ff) begin
               state_in = ins_ff ? ST_PLACE : ST_REPORT;
            end
         end
         ST_PLACE: begin
            state_in = ST_REPORT;
         end
         ST_EMIT: begin
            if (have_ff && out_free && left_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_REPORT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs: memory port controls and the result handed to the output register.
   always_comb begin
      req_ready  = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = wr_addr_ff;
      mem_wdata  = mem_rdata;
      mem_re     = 1'b0;
      mem_raddr  = rd_addr_ff;
      res.load   = 1'b0;
      res.value  = '0;
      res.status = status_ff;
      res.count  = count_ff;
      res.last   = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_SHIFT: begin
            mem_re = (left_ff != '0);
            mem_we = wr_pend_ff;
         end
         ST_PLACE: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = data_ff;
         end
         ST_EMIT: begin
            mem_re    = !have_ff || (out_free && left_ff != CNT_W'(1));
            res.load  = have_ff && out_free;
            res.value = mem_rdata;
            res.last  = (left_ff == CNT_W'(1));
         end
         ST_REPORT: begin
            res.load = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Datapath registers.
   always_comb begin
      count_in   = count_ff;
      left_in    = left_ff;
      rd_addr_in = rd_addr_ff;
      wr_addr_in = wr_addr_ff;
      pos_in     = pos_ff;
      data_in    = data_ff;
      status_in  = status_ff;
      wr_pend_in = 1'b0;
      have_in    = have_ff;
      ins_in     = ins_ff;
      fwd_in     = fwd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               left_in    = dec_left;
               rd_addr_in = dec_rd;
               pos_in     = req_pos[AW-1:0];
               data_in    = req_data;
               status_in  = dec_status;
               have_in    = 1'b0;
               ins_in     = dec_ins;
               fwd_in     = dec_fwd;
            end
         end
         ST_SHIFT: begin
            if (left_ff != '0) begin
               // The word read now lands one place up (insert) or down (remove).
               wr_pend_in = 1'b1;
               wr_addr_in = ins_ff ? rd_addr_ff + AW'(1) : rd_addr_ff - AW'(1);
               rd_addr_in = rd_step;
               left_in    = left_ff - CNT_W'(1);
            end else if (!wr_pend_ff && !ins_ff) begin
               count_in = cnt_m1;
            end
         end
         ST_PLACE: begin
            count_in = count_ff + CNT_W'(1);
         end
         ST_EMIT: begin
            if (!have_ff) begin
               have_in    = 1'b1;
               rd_addr_in = rd_step;
            end else if (out_free) begin
               left_in = left_ff - CNT_W'(1);
               if (left_ff != CNT_W'(1)) begin
                  rd_addr_in = rd_step;
               end
            end
         end
         ST_REPORT: begin
            have_in = 1'b0;
         end
         default: begin
            have_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         wr_pend_ff <= 1'b0;
         have_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         wr_pend_ff <= wr_pend_in;
         have_ff    <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff    <= left_in;
      rd_addr_ff <= rd_addr_in;
      wr_addr_ff <= wr_addr_in;
      pos_ff     <= pos_in;
      data_ff    <= data_in;
      status_ff  <= status_in;
      ins_ff     <= ins_in;
      fwd_ff     <= fwd_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("list fill level exceeds capacity");

   assert property (@(posedge clock) disable iff (reset)
      mem_we && mem_re |-> mem_waddr != mem_raddr)
      else $error("memory read and write collide on one entry");

   assert property (@(posedge clock) disable iff (reset)
      res.load |-> out_free)
      else $error("result loaded while output register still occupied");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> left_ff != '0)
      else $error("emit phase with no words left to send");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PLACE |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not raise the fill level by one");

endmodule

`default_nettype wire

FILE: tb/sv/tb_shifting_array_list.sv
`timescale 1ns / 100ps

module tb_shifting_array_list;
   import sal_pkg::*;

   localparam int LIST_DEPTH  = DEPTH_DEF;
   localparam int MAX_POS     = LIST_DEPTH;
   localparam int TAIL_CYCLES = 100;
   // Worst case: every request a full traversal with every word held off by the
   // longest stall, taken several times over.
   localparam int CYCLE_LIMIT = 10_000_000;

   // Selector codes the block ignores.
   localparam logic [FUNC_W-1:0] FN_SPARE_A = 3'd5;
   localparam logic [FUNC_W-1:0] FN_SPARE_B = 3'd6;
   localparam logic [FUNC_W-1:0] FN_SPARE_C = 3'd7;

   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

   typedef struct {
      logic signed [DATA_W-1:0] word;
      status_type               stat;
      logic [CNT_W-1:0]         fill;
      logic                     is_last;
   } list_result_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic [FUNC_W-1:0]        req_func  = '0;
   logic [CNT_W-1:0]         req_pos   = '0;
   logic signed [DATA_W-1:0] req_data  = '0;
   logic                     rsp_ready = 1'b0;
   logic                     req_ready;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_value;
   logic [STATUS_W-1:0]      rsp_status;
   logic [CNT_W-1:0]         rsp_count;
   logic                     rsp_last;

   logic signed [DATA_W-1:0] list_words[$];
   list_result_type          expected_results[$];

   int  error_count     = 0;
   int  requests_sent   = 0;
   int  results_checked = 0;
   int  peak_fill       = 0;
   int  full_flags      = 0;
   int  range_flags     = 0;
   int  empty_flags     = 0;
   int  hold_request    = 0;
   int  stall_left      = 0;
   int  cycle_count     = 0;
   bit  sender_idle_on   = 1'b1;
   bit  receiver_idle_on = 1'b1;

   shifting_array_list #(
      .DEPTH(LIST_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .req_pos   (req_pos),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_value (rsp_value),
      .rsp_status(rsp_status),
      .rsp_count (rsp_count),
      .rsp_last  (rsp_last)
   );

   always #5 clock = ~clock;

   // Mostly no gap, sometimes a few cycles, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [DATA_W-1:0] random_word();
      case ($urandom_range(0, 15))
         0:       return WORD_MAX;
         1:       return WORD_MIN;
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic void queue_result(input logic signed [DATA_W-1:0] word,
                                        input status_type stat, input logic is_last);
      list_result_type r;
      r.word    = word;
      r.stat    = stat;
      r.fill    = CNT_W'(list_words.size());
      r.is_last = is_last;
      expected_results.push_back(r);
      case (stat)
         STAT_FULL:  full_flags++;
         STAT_RANGE: range_flags++;
         STAT_EMPTY: empty_flags++;
         default:    ;
      endcase
   endfunction

   // Applies one accepted request to the list copy and queues what it yields.
   function automatic void predict_list_op(input logic [FUNC_W-1:0] fn,
                                           input logic [CNT_W-1:0] p,
                                           input logic signed [DATA_W-1:0] d);
      int n;
      n = list_words.size();
      case (fn)
         FN_READ, FN_REMOVE: begin
            if (n == 0) begin
               queue_result('0, STAT_EMPTY, 1'b1);
            end else if (p >= n) begin
               queue_result('0, STAT_RANGE, 1'b1);
            end else if (fn == FN_READ) begin
               queue_result(list_words[p], STAT_OK, 1'b1);
            end else begin
               list_words.delete(p);
               queue_result('0, STAT_OK, 1'b1);
            end
         end
         FN_INSERT: begin
            // A full list is flagged before the position is looked at.
            if (n >= LIST_DEPTH) begin
               queue_result('0, STAT_FULL, 1'b1);
            end else if (p > n) begin
               queue_result('0, STAT_RANGE, 1'b1);
            end else begin
               list_words.insert(p, d);
               queue_result('0, STAT_OK, 1'b1);
            end
         end
         FN_FWD, FN_BWD: begin
            if (n == 0) begin
               queue_result('0, STAT_EMPTY, 1'b1);
            end else begin
               for (int i = 0; i < n; i++)
                  queue_result(list_words[fn == FN_FWD ? i : n - 1 - i], STAT_OK, i == n - 1);
            end
         end
         default: queue_result('0, STAT_OK, 1'b1);
      endcase
      if (list_words.size() > peak_fill) peak_fill = list_words.size();
   endfunction

   // Valid is left high on return so that a following request can go out on
   // the very next edge.
   task automatic send_request(input logic [FUNC_W-1:0] fn, input logic [CNT_W-1:0] p,
                               input logic signed [DATA_W-1:0] d);
      int gap;
      gap = sender_idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= fn;
      req_pos   <= p;
      req_data  <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_list_op(fn, p, d);
      requests_sent++;
   endtask

   task automatic wait_list_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic test_directed_edge_cases();
      send_request(FN_READ, '0, '0);
      send_request(FN_REMOVE, '0, '0);
      send_request(FN_FWD, '0, '0);
      send_request(FN_BWD, '0, '0);
      send_request(FN_INSERT, 7'd1, WORD_MAX);
      send_request(FN_SPARE_A, 7'd3, WORD_MIN);
      send_request(FN_SPARE_C, CNT_W'(MAX_POS), '1);
      send_request(FN_INSERT, 7'd0, WORD_MAX);
      send_request(FN_INSERT, 7'd0, WORD_MIN);
      send_request(FN_INSERT, 7'd2, '1);
      send_request(FN_INSERT, 7'd1, '0);
      send_request(FN_READ, CNT_W'(MAX_POS), '0);
      send_request(FN_READ, 7'd4, '0);
      send_request(FN_REMOVE, 7'd4, '0);
      send_request(FN_INSERT, 7'd6, 32'sh1234_5678);
      send_request(FN_FWD, '0, '0);
      send_request(FN_BWD, '0, '0);
      send_request(FN_READ, 7'd0, '0);
      send_request(FN_READ, 7'd3, '0);
      send_request(FN_REMOVE, 7'd0, '0);
      send_request(FN_REMOVE, 7'd2, '0);
      send_request(FN_FWD, '0, '0);
      send_request(FN_SPARE_B, 7'd1, '0);
      wait_list_idle();
   endtask

   task automatic test_fill_to_capacity();
      while (list_words.size() < LIST_DEPTH)
         send_request(FN_INSERT, CNT_W'($urandom_range(0, list_words.size())),
                      random_word());
      send_request(FN_INSERT, '0, random_word());
      send_request(FN_INSERT, CNT_W'(MAX_POS), random_word());
      send_request(FN_READ, CNT_W'(LIST_DEPTH - 1), '0);
      send_request(FN_READ, CNT_W'(MAX_POS), '0);
      send_request(FN_REMOVE, CNT_W'(MAX_POS), '0);
      send_request(FN_FWD, '0, '0);
      send_request(FN_BWD, '0, '0);
      wait_list_idle();
   endtask

   // The receiver holds off while requests keep coming, so the block backs up
   // into its input; the sender then waits for everything to come out.
   task automatic test_output_backpressure();
      sender_idle_on = 1'b0;
      hold_request   = 400;
      send_request(FN_FWD, '0, '0);
      send_request(FN_BWD, '0, '0);
      send_request(FN_READ, CNT_W'($urandom_range(0, LIST_DEPTH - 1)), '0);
      send_request(FN_REMOVE, CNT_W'($urandom_range(0, LIST_DEPTH - 1)), '0);
      send_request(FN_INSERT, CNT_W'($urandom_range(0, LIST_DEPTH - 1)), random_word());
      send_request(FN_FWD, '0, '0);
      sender_idle_on = 1'b1;
      wait_list_idle();
   endtask

   // Mostly well-formed edits, in phases that alternately empty and fill the
   // list, with a share of out-of-range positions and unused selectors.
   task automatic test_random_edits(input int n_items);
      int                       n, r, lo, ins_w, rem_w;
      logic [FUNC_W-1:0]        fn;
      logic [CNT_W-1:0]         p;
      logic signed [DATA_W-1:0] d;
      for (int k = 0; k < n_items; k++) begin
         n     = list_words.size();
         ins_w = ((k / 120) % 2 == 1) ? 65 : 5;
         rem_w = 70 - ins_w;
         d     = random_word();
         p     = CNT_W'($urandom_range(0, MAX_POS));
         r     = $urandom_range(0, 99);
         if (r < 85) begin
            r = $urandom_range(0, 99);
            if (r < ins_w) begin
               fn = FN_INSERT;
               p  = CNT_W'($urandom_range(0, n));
            end else if (r < 88) begin
               fn = (r < ins_w + rem_w) ? FN_REMOVE : FN_READ;
               if (n > 0) p = CNT_W'($urandom_range(0, n - 1));
            end else begin
               fn = $urandom_range(0, 1) ? FN_FWD : FN_BWD;
            end
         end else begin
            case ($urandom_range(0, 2))
               0: fn = FUNC_W'($urandom_range(FN_SPARE_A, FN_SPARE_C));
               1: begin
                  case ($urandom_range(0, 2))
                     0:       fn = FN_READ;
                     1:       fn = FN_REMOVE;
                     default: fn = FN_INSERT;
                  endcase
                  lo = (fn == FN_INSERT) ? n + 1 : n;
                  if (lo > MAX_POS) lo = MAX_POS;
                  p = CNT_W'($urandom_range(lo, MAX_POS));
               end
               default: fn = FUNC_W'($urandom_range(FN_READ, FN_SPARE_C));
            endcase
         end
         send_request(fn, p, d);
      end
      wait_list_idle();
   endtask

   task automatic test_back_to_back();
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      test_random_edits(30);
      sender_idle_on   = 1'b1;
      receiver_idle_on = 1'b1;
   endtask

   task automatic test_drain_to_empty();
      while (list_words.size() > 0)
         send_request(FN_REMOVE, CNT_W'($urandom_range(0, list_words.size() - 1)), '0);
      send_request(FN_READ, '0, '0);
      send_request(FN_REMOVE, '0, '0);
      send_request(FN_FWD, '0, '0);
      send_request(FN_BWD, '0, '0);
      send_request(FN_INSERT, CNT_W'(MAX_POS), random_word());
      wait_list_idle();
   endtask

   // Result side: random stalls, plus a long hold when a test asks for one.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         stall_left   = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (receiver_idle_on && $urandom_range(0, 99) < 25) begin
         stall_left = pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $error("result with no request outstanding: value %0d status %0d",
                   rsp_value, rsp_status);
            error_count++;
         end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (rsp_value !== want.word) begin
               $error("value mismatch: expected %0d, got %0d", want.word, rsp_value);
               error_count++;
            end
            if (rsp_status !== want.stat) begin
               $error("status mismatch: expected %0d, got %0d", want.stat, rsp_status);
               error_count++;
            end
            if (rsp_count !== want.fill) begin
               $error("count mismatch: expected %0d, got %0d", want.fill, rsp_count);
               error_count++;
            end
            if (rsp_last !== want.is_last) begin
               $error("last mismatch: expected %0d, got %0d", want.is_last, rsp_last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, expected_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed_edge_cases();
      test_fill_to_capacity();
      test_output_backpressure();
      test_back_to_back();
      test_random_edits(220);
      test_drain_to_empty();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         $error("%0d results never arrived", expected_results.size());
         error_count++;
      end
      $display("Sent %0d requests and checked %0d results; the list reached %0d of %0d words.",
               requests_sent, results_checked, peak_fill, LIST_DEPTH);
      $display("Flagged results seen: %0d full, %0d out of range, %0d empty.",
               full_flags, range_flags, empty_flags);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/sal_pkg.sv
hdl/sal_ram.sv
hdl/sal_ctrl.sv
hdl/shifting_array_list.sv
tb/sv/tb_shifting_array_list.sv
